### hdl/imu_angle_frame_parser_assert.svh
// Assertion macros for the inertial sensor angle frame parser.
`ifndef IMU_ANGLE_FRAME_PARSER_ASSERT_SVH
`define IMU_ANGLE_FRAME_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

`define IAFP_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("iafp assertion failed");

`define IAFP_ASSERT_NEVER(lbl, ck, rs, expr) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(expr)) \
    else $error("iafp forbidden condition");

`else

`define IAFP_ASSERT(lbl, ck, rs, prop)

`define IAFP_ASSERT_NEVER(lbl, ck, rs, expr)

`endif

`endif

### hdl/iafp_pkg.sv
// Package: constants, types and angle scaling for the angle frame parser.
`default_nettype none

package iafp_pkg;

  localparam int FRAME_LEN = 11;

  localparam logic [3:0] LAST_IDX   = 4'(FRAME_LEN - 1);
  localparam logic [3:0] STORE_LEN  = 4'd8;
  localparam logic [7:0] HDR0       = 8'h55;
  localparam logic [7:0] HDR1       = 8'h53;
  localparam logic [16:0] ANGLE_OFFSET = 17'd46080;

  typedef logic signed [16:0] angle_t;

  typedef struct packed {
    logic [15:0] roll_code;
    logic [15:0] pitch_code;
    logic [15:0] yaw_code;
  } frame_codes_t;

  // floor(code*45/32) for a signed 16-bit code, via the biased form
  function automatic angle_t scale_angle(input logic [15:0] code);
    logic [15:0] biased;
    logic [21:0] prod;
    logic [16:0] scaled;
    biased = code ^ 16'h8000;
    prod   = {1'b0, biased, 5'b0} + {3'b0, biased, 3'b0}
           + {4'b0, biased, 2'b0} + {6'b0, biased};
    scaled = prod[21:5];
    return $signed(scaled - ANGLE_OFFSET);
  endfunction

endpackage

`default_nettype wire

### hdl/iafp_byte_if.sv
// Byte channel: one received byte and its burst end flag per item.
`default_nettype none

interface iafp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       burst_end;

  modport source (output valid, rx_byte, burst_end, input ready);
  modport sink   (input valid, rx_byte, burst_end, output ready);
endinterface

`default_nettype wire

### hdl/iafp_angle_if.sv
// Angle channel: roll, pitch and yaw of one good frame per item.
`default_nettype none

interface iafp_angle_if;
  logic                valid;
  logic                ready;
  iafp_pkg::angle_t    roll_angle;
  iafp_pkg::angle_t    pitch_angle;
  iafp_pkg::angle_t    yaw_angle;

  modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

`default_nettype wire

### hdl/iafp_frame_acc.sv
// Frame accumulator: byte count, running sum, stored bytes and frame check.
`default_nettype none

module iafp_frame_acc (
  input  wire logic                   clk,
  input  wire logic                   rst,
  iafp_byte_if.sink                   byte_in,
  output logic                        frame_valid,
  input  wire logic                   frame_ready,
  output iafp_pkg::frame_codes_t      frame_codes
);

  logic [3:0] byte_count;
  logic [7:0] running_sum;
  logic [7:0] frame_bytes [8];
  logic       accept;
  logic       completing;
  logic       good;

  assign byte_in.ready = !frame_valid || frame_ready;
  assign accept        = byte_in.valid && byte_in.ready;
  assign completing    = (byte_count >= iafp_pkg::LAST_IDX);
  assign good          = (frame_bytes[0] == iafp_pkg::HDR0)
                      && (frame_bytes[1] == iafp_pkg::HDR1)
                      && (byte_in.rx_byte == running_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      running_sum <= '0;
      frame_valid <= 1'b0;
    end else begin
      if (frame_ready) begin
        frame_valid <= 1'b0;
      end
      if (accept) begin
        if (!completing) begin
          running_sum <= running_sum + byte_in.rx_byte;
          byte_count  <= byte_count + 4'd1;
        end else begin
          if (good) begin
            frame_valid <= 1'b1;
          end
          running_sum <= '0;
          byte_count  <= '0;
        end
        if (byte_in.burst_end) begin
          running_sum <= '0;
          byte_count  <= '0;
        end
      end
    end
  end

  // payload: angle bytes only ever land at offsets below eight
  always_ff @(posedge clk) begin
    if (accept && (byte_count < iafp_pkg::STORE_LEN)) begin
      frame_bytes[byte_count[2:0]] <= byte_in.rx_byte;
    end
    if (accept && completing && good) begin
      frame_codes.roll_code  <= {frame_bytes[3], frame_bytes[2]};
      frame_codes.pitch_code <= {frame_bytes[5], frame_bytes[4]};
      frame_codes.yaw_code   <= {frame_bytes[7], frame_bytes[6]};
    end
  end

endmodule

`default_nettype wire

### hdl/iafp_angle_scale.sv
// Angle scaling stage: codes to 1/256 degree into the result register.
`default_nettype none

module iafp_angle_scale (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   frame_valid,
  output logic                        frame_ready,
  input  wire iafp_pkg::frame_codes_t frame_codes,
  iafp_angle_if.source                angle_out
);

  logic load;

  assign frame_ready = !angle_out.valid || angle_out.ready;
  assign load        = frame_valid && frame_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_out.valid <= 1'b0;
    end else if (load) begin
      angle_out.valid <= 1'b1;
    end else if (angle_out.ready) begin
      angle_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      angle_out.roll_angle  <= iafp_pkg::scale_angle(frame_codes.roll_code);
      angle_out.pitch_angle <= iafp_pkg::scale_angle(frame_codes.pitch_code);
      angle_out.yaw_angle   <= iafp_pkg::scale_angle(frame_codes.yaw_code);
    end
  end

endmodule

`default_nettype wire

### hdl/imu_angle_frame_parser.sv
// Top level of the inertial sensor angle frame parser.
//
//   channel    dir  payload                                  per item
//   byte_in    in   rx_byte[7:0], burst_end                  one frame byte
//   angle_out  out  roll/pitch/yaw_angle, signed [16:0]      one good frame
//
// One byte is taken per cycle while byte_in.ready is high; a good frame's
// angles go from its checksum byte into the frame check register, then
// through scaling into the result register. Reset clears the count, the sum
// and both valid flags; stored bytes are not cleared. A stalled result holds;
// bytes keep flowing until the check register is also full.
`default_nettype none
`include "imu_angle_frame_parser_assert.svh"

module imu_angle_frame_parser (
  input  wire logic     clk,
  input  wire logic     rst,
  iafp_byte_if.sink     byte_in,
  iafp_angle_if.source  angle_out
);

  logic                   frame_valid;
  logic                   frame_ready;
  iafp_pkg::frame_codes_t frame_codes;

  iafp_frame_acc u_acc (
    .clk         (clk),
    .rst         (rst),
    .byte_in     (byte_in),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame_codes (frame_codes)
  );

  iafp_angle_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame_codes (frame_codes),
    .angle_out   (angle_out)
  );

  `IAFP_ASSERT(a_frame_held, clk, rst, frame_valid && !frame_ready |=> frame_valid && $stable(frame_codes))
  `IAFP_ASSERT(a_frame_to_result, clk, rst, frame_valid && frame_ready |=> angle_out.valid)
  `IAFP_ASSERT_NEVER(a_no_overrun, clk, rst, angle_out.valid && !angle_out.ready && frame_valid && byte_in.ready)

endmodule

`default_nettype wire
